// ----- hw/rtl/esdm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed and direction meter package
// Shared widths, register map, rotation codes and arithmetic constants.
// ----------------------------------------------------------------------------
package esdm_pkg;

  // Field widths
  localparam int unsigned RawW   = 32;
  localparam int unsigned PosW   = 32;
  localparam int unsigned SpeedW = 31;
  localparam int unsigned StepW  = 16;
  localparam int unsigned RotW   = 2;
  localparam int unsigned CfgW   = 16;

  // Configuration port geometry
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register indexes (paddr[2])
  localparam logic RegCountsPerRev = 1'b0;
  localparam logic RegSamplePeriod = 1'b1;

  // Register reset values
  localparam logic [CfgW-1:0] CountsPerRevRst = 16'd1024;
  localparam logic [CfgW-1:0] SamplePeriodRst = 16'd10;

  // Rotation codes
  localparam logic [RotW-1:0] RotStopped = 2'd0;
  localparam logic [RotW-1:0] RotCw      = 2'd1;
  localparam logic [RotW-1:0] RotCcw     = 2'd2;

  // Speed scale: counts per millisecond to revolutions per minute
  localparam logic [CfgW-1:0] SpeedScale = 16'd60000;

  // Divider: one quotient bit per cycle
  localparam int unsigned DivSteps = SpeedW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

endpackage

// ----- hw/rtl/encoder_speed_direction_meter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed and direction meter
// Samples a free-running encoder counter and reports position, speed and
// direction, with the speed quotient formed by a bit-serial divider.
// ----------------------------------------------------------------------------
// Each accepted sample of raw_count_i yields exactly one result transfer. The
// step since the previous sample is wrapped to 16 bits, added into a wrapping
// 32-bit position, and speed_rpm = |step| * 60000 / (counts_per_rev *
// sample_period_ms), truncated. The first sample after reset only sets the
// baseline and reports a step of zero. The step is captured at the input
// transfer; the two products are then registered, the restoring divider
// produces one quotient bit per cycle, and the result is loaded into the
// output register once that register is free. The input is not ready while
// a sample is being worked on, so a new sample is accepted only after the
// previous result has been loaded. A finished result sits in the output
// register, so the next sample may enter while it waits. Writes of zero to
// either register are ignored.
module encoder_speed_direction_meter_unit
  import esdm_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ApbAddrW-1:0]        paddr,
  input  logic [ApbDataW-1:0]        pwdata,
  output logic [ApbDataW-1:0]        prdata,
  output logic                       pready,
  // Sample input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [RawW-1:0]     raw_count_i,
  // Result output channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [PosW-1:0]     position_count_o,
  output logic [SpeedW-1:0]          speed_rpm_o,
  output logic [RotW-1:0]            rotation_o,
  output logic signed [StepW-1:0]    step_delta_o
);

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDiv,
    StDone
  } state_e;

  state_e                state_q;
  logic [CfgW-1:0]       counts_per_rev_q;
  logic [CfgW-1:0]       sample_period_q;
  logic [RawW-1:0]       prev_raw_q;
  logic                  baseline_q;
  logic [PosW-1:0]       position_q;
  logic [StepW-1:0]      step_q;
  logic [RotW-1:0]       rot_q;
  logic [StepW-1:0]      mag_q;
  logic [PosW-1:0]       den_q;
  logic [PosW-1:0]       rem_q;
  logic [SpeedW-1:0]     quo_q;
  logic [DivCntW-1:0]    cnt_q;
  logic                  out_valid_q;
  logic [PosW-1:0]       out_pos_q;
  logic [SpeedW-1:0]     out_speed_q;
  logic [RotW-1:0]       out_rot_q;
  logic [StepW-1:0]      out_step_q;

  logic                  cfg_wr;
  logic                  in_xfer;
  logic                  out_load;
  logic [RawW-1:0]       raw_diff;
  logic [StepW-1:0]      step_d;
  logic [StepW-1:0]      mag_d;
  logic [RotW-1:0]       rot_d;
  logic [PosW-1:0]       position_d;
  logic [PosW-1:0]       num_prod;
  logic [PosW-1:0]       den_prod;
  logic [PosW:0]         rem_shift;
  logic                  fits;
  logic [PosW-1:0]       rem_d;

  // Configuration port: writes complete in the access phase, reads are muxed.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[2])
      RegCountsPerRev: prdata = {{(ApbDataW-CfgW){1'b0}}, counts_per_rev_q};
      RegSamplePeriod: prdata = {{(ApbDataW-CfgW){1'b0}}, sample_period_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_per_rev_q <= CountsPerRevRst;
      sample_period_q  <= SamplePeriodRst;
    end else if (cfg_wr && (pwdata[CfgW-1:0] != '0)) begin
      case (paddr[2])
        RegCountsPerRev: counts_per_rev_q <= pwdata[CfgW-1:0];
        RegSamplePeriod: sample_period_q  <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes
  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign out_load   = (state_q == StDone) & (~out_valid_q | out_ready_i);

  // Step, magnitude, direction and new position for an incoming sample.
  assign raw_diff   = raw_count_i - prev_raw_q;
  assign step_d     = baseline_q ? raw_diff[StepW-1:0] : '0;
  assign mag_d      = step_d[StepW-1] ? (StepW'(0) - step_d) : step_d;
  assign position_d = position_q + {{(PosW-StepW){step_d[StepW-1]}}, step_d};

  always_comb begin
    if (step_d[StepW-1]) begin
      rot_d = RotCcw;
    end else if (step_d != '0) begin
      rot_d = RotCw;
    end else begin
      rot_d = RotStopped;
    end
  end

  // Numerator and divisor products, each 16 by 16 bits.
  assign num_prod = PosW'(mag_q) * PosW'(SpeedScale);
  assign den_prod = PosW'(counts_per_rev_q) * PosW'(sample_period_q);

  // One restoring division step: shift in the next numerator bit and
  // subtract the divisor when it fits.
  assign rem_shift = {rem_q, quo_q[SpeedW-1]};
  assign fits      = (rem_shift >= {1'b0, den_q});
  assign rem_d     = fits ? PosW'(rem_shift - {1'b0, den_q}) : rem_shift[PosW-1:0];

  // Sequencer, divider and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_raw_q  <= '0;
      baseline_q  <= 1'b0;
      position_q  <= '0;
      step_q      <= '0;
      rot_q       <= RotStopped;
      mag_q       <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_speed_q <= '0;
      out_rot_q   <= RotStopped;
      out_step_q  <= '0;
    end else begin
      // The output register takes a finished result, or empties once taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            prev_raw_q <= raw_count_i;
            baseline_q <= 1'b1;
            position_q <= position_d;
            step_q     <= step_d;
            rot_q      <= rot_d;
            mag_q      <= mag_d;
            state_q    <= StMul;
          end
        end
        StMul: begin
          quo_q   <= num_prod[SpeedW-1:0];
          den_q   <= den_prod;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          rem_q <= rem_d;
          quo_q <= {quo_q[SpeedW-2:0], fits};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivCntW'(DivSteps - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_load) begin
            out_pos_q   <= position_q;
            out_speed_q <= quo_q;
            out_rot_q   <= rot_q;
            out_step_q  <= step_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign position_count_o = out_pos_q;
  assign speed_rpm_o      = out_speed_q;
  assign rotation_o       = out_rot_q;
  assign step_delta_o     = out_step_q;

endmodule
